// ===== src/tksd_pkg.sv =====
package tksd_pkg;

  // Field widths
  localparam int ByteW  = 8;
  localparam int KeyW   = 5;
  localparam int NumW   = 16;

  // Default limit on counted parameter fields
  localparam int MAX_PARAMS = 10;

  // Byte codes
  localparam logic [ByteW-1:0] CH_ESC   = 8'h1B;
  localparam logic [ByteW-1:0] CH_CSI   = 8'h5B;  // '['
  localparam logic [ByteW-1:0] CH_SS3   = 8'h4F;  // 'O'
  localparam logic [ByteW-1:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [ByteW-1:0] CH_TILDE = 8'h7E;  // '~'
  localparam logic [ByteW-1:0] CH_R     = 8'h52;  // 'R'
  localparam logic [ByteW-1:0] CH_P     = 8'h50;  // 'P'
  localparam logic [ByteW-1:0] CH_Q     = 8'h51;  // 'Q'
  localparam logic [ByteW-1:0] CH_S     = 8'h53;  // 'S'
  localparam logic [ByteW-1:0] CH_A     = 8'h41;  // 'A'
  localparam logic [ByteW-1:0] CH_D     = 8'h44;  // 'D'
  localparam logic [ByteW-1:0] CH_0     = 8'h30;  // '0'
  localparam logic [ByteW-1:0] CH_9     = 8'h39;  // '9'

  // Key codes
  localparam logic [KeyW-1:0] KEY_NONE      = 5'd0;
  localparam logic [KeyW-1:0] KEY_ESC       = 5'd1;
  localparam logic [KeyW-1:0] KEY_ALT       = 5'd2;
  localparam logic [KeyW-1:0] KEY_UP        = 5'd3;
  localparam logic [KeyW-1:0] KEY_DOWN      = 5'd4;
  localparam logic [KeyW-1:0] KEY_RIGHT     = 5'd5;
  localparam logic [KeyW-1:0] KEY_LEFT      = 5'd6;
  localparam logic [KeyW-1:0] KEY_CTRL_UP   = 5'd7;
  localparam logic [KeyW-1:0] KEY_INSERT    = 5'd11;
  localparam logic [KeyW-1:0] KEY_DELETE    = 5'd12;
  localparam logic [KeyW-1:0] KEY_PGUP      = 5'd13;
  localparam logic [KeyW-1:0] KEY_PGDN      = 5'd14;
  localparam logic [KeyW-1:0] KEY_F1        = 5'd15;
  localparam logic [KeyW-1:0] KEY_F2        = 5'd16;
  localparam logic [KeyW-1:0] KEY_F3        = 5'd17;
  localparam logic [KeyW-1:0] KEY_F4        = 5'd18;
  localparam logic [KeyW-1:0] KEY_F5        = 5'd19;
  localparam logic [KeyW-1:0] KEY_F6        = 5'd20;
  localparam logic [KeyW-1:0] KEY_F7        = 5'd21;
  localparam logic [KeyW-1:0] KEY_F8        = 5'd22;
  localparam logic [KeyW-1:0] KEY_F9        = 5'd23;
  localparam logic [KeyW-1:0] KEY_F10       = 5'd24;
  localparam logic [KeyW-1:0] KEY_F11       = 5'd25;
  localparam logic [KeyW-1:0] KEY_F12       = 5'd26;
  localparam logic [KeyW-1:0] KEY_SIZE_NEW  = 5'd27;
  localparam logic [KeyW-1:0] KEY_SIZE_SAME = 5'd28;

  // Parser phase
  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_INTRO = 3'b010,
    PH_PARAM = 3'b100
  } phase_t;

  // Input word
  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
    logic             end_of_input;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [KeyW-1:0] key_code;
    logic [NumW-1:0] screen_rows;
    logic [NumW-1:0] screen_cols;
  } out_word_t;

  // Result from the decode stage to the output register
  typedef struct packed {
    logic      valid;
    out_word_t word;
  } result_t;

  // ESC [ n ~ lookup
  function automatic logic [KeyW-1:0] tilde_key(input logic [NumW-1:0] n);
    logic [KeyW-1:0] k;
    k = KEY_NONE;
    unique case (n)
      16'd2:   k = KEY_INSERT;
      16'd3:   k = KEY_DELETE;
      16'd5:   k = KEY_PGUP;
      16'd6:   k = KEY_PGDN;
      16'd15:  k = KEY_F5;
      16'd17:  k = KEY_F6;
      16'd18:  k = KEY_F7;
      16'd19:  k = KEY_F8;
      16'd20:  k = KEY_F9;
      16'd21:  k = KEY_F10;
      16'd23:  k = KEY_F11;
      16'd24:  k = KEY_F12;
      default: k = KEY_NONE;
    endcase
    return k;
  endfunction

  // ESC O x lookup
  function automatic logic [KeyW-1:0] ss3_key(input logic [ByteW-1:0] b);
    logic [KeyW-1:0] k;
    k = KEY_NONE;
    unique case (b)
      8'h41:   k = KEY_UP;
      8'h42:   k = KEY_DOWN;
      8'h43:   k = KEY_RIGHT;
      8'h44:   k = KEY_LEFT;
      CH_P:    k = KEY_F1;
      CH_Q:    k = KEY_F2;
      CH_R:    k = KEY_F3;
      CH_S:    k = KEY_F4;
      default: k = KEY_NONE;
    endcase
    return k;
  endfunction

endpackage

// ===== src/tksd_in_stage.sv =====
module tksd_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tksd_pkg::in_word_t in_word,
  input  logic              take,
  output logic              held_valid,
  output tksd_pkg::in_word_t held_word
);
  import tksd_pkg::*;

  // Stage is refilled when empty or drained this cycle
  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_word <= in_word;
    end
  end

endmodule

// ===== src/tksd_core.sv =====
module tksd_core #(
  parameter int MaxParams = tksd_pkg::MAX_PARAMS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  tksd_pkg::in_word_t word,
  output tksd_pkg::result_t  result
);
  import tksd_pkg::*;

  localparam int CntW = $clog2(MaxParams + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxParams);
  localparam logic [CntW-1:0] CntZero = '0;
  localparam logic [CntW-1:0] CntOne  = CntW'(1);
  localparam logic [CntW-1:0] CntTwo  = CntW'(2);

  phase_t           phase, phase_next;
  logic [ByteW-1:0] intro, intro_next;
  logic [NumW-1:0]  accum, accum_next;
  logic             have, have_next;
  logic [CntW-1:0]  pcount, pcount_next;
  logic [NumW-1:0]  first, first_next;
  logic [NumW-1:0]  second, second_next;
  logic [NumW-1:0]  rows, rows_next;
  logic [NumW-1:0]  cols, cols_next;

  logic [ByteW-1:0] b;
  logic             eoi;
  logic             is_digit;
  logic [19:0]      acc_mul;
  logic [CntW-1:0]  push_cnt, eff_cnt;
  logic [NumW-1:0]  push_first, push_second, eff_first, eff_second;
  logic [1:0]       slot;
  logic [KeyW-1:0]  csi_key;
  logic             size_upd;

  assign b        = word.rx_byte;
  assign eoi      = word.end_of_input;
  assign is_digit = (b >= CH_0) && (b <= CH_9);

  // Decimal accumulate, x10 as shift-add
  assign acc_mul = {1'b0, accum, 3'b000} + {3'b000, accum, 1'b0} + {16'd0, b[3:0]};

  // Values after closing the current field
  always_comb begin
    push_cnt    = pcount;
    push_first  = first;
    push_second = second;
    if (pcount < CntMax) begin
      if (pcount == CntZero) begin
        push_first = accum;
      end else if (pcount == CntOne) begin
        push_second = accum;
      end
      push_cnt = pcount + CntOne;
    end
  end

  // Final byte closes the field only when it holds digits
  assign eff_cnt    = have ? push_cnt    : pcount;
  assign eff_first  = have ? push_first  : first;
  assign eff_second = have ? push_second : second;

  // CSI final byte decode
  assign slot = b[1:0] - 2'd1;
  always_comb begin
    csi_key  = KEY_NONE;
    size_upd = 1'b0;
    if (b >= CH_A && b <= CH_D) begin
      if (eff_cnt == CntTwo && eff_first == 16'd1 && eff_second == 16'd5) begin
        csi_key = KEY_CTRL_UP + {3'b000, slot};
      end else if (eff_cnt == CntZero) begin
        csi_key = KEY_UP + {3'b000, slot};
      end
    end else if (b == CH_TILDE) begin
      if (eff_cnt == CntOne) begin
        csi_key = tilde_key(eff_first);
      end
    end else if (b == CH_R) begin
      if (eff_cnt == CntTwo) begin
        size_upd = 1'b1;
        csi_key  = ((rows != eff_first) || (cols != eff_second)) ? KEY_SIZE_NEW
                                                                  : KEY_SIZE_SAME;
      end
    end
  end

  // Per-byte parser step
  always_comb begin
    phase_next   = phase;
    intro_next   = intro;
    accum_next   = accum;
    have_next    = have;
    pcount_next  = pcount;
    first_next   = first;
    second_next  = second;
    rows_next    = rows;
    cols_next    = cols;
    result.valid = 1'b0;
    result.word.key_code = KEY_NONE;

    unique case (phase)
      PH_INTRO: begin
        if (eoi) begin
          phase_next   = PH_IDLE;
          result.valid = 1'b1;
          result.word.key_code = KEY_ESC;
        end else begin
          intro_next  = b;
          accum_next  = '0;
          have_next   = 1'b0;
          pcount_next = '0;
          first_next  = '0;
          second_next = '0;
          phase_next  = PH_PARAM;
        end
      end
      PH_PARAM: begin
        if (eoi) begin
          pcount_next  = eff_cnt;
          first_next   = eff_first;
          second_next  = eff_second;
          accum_next   = '0;
          have_next    = 1'b0;
          phase_next   = PH_IDLE;
          result.valid = 1'b1;
          result.word.key_code = (intro == CH_CSI || intro == CH_SS3) ? KEY_NONE : KEY_ALT;
        end else if (is_digit) begin
          accum_next = (acc_mul > 20'd65535) ? 16'hFFFF : acc_mul[NumW-1:0];
          have_next  = 1'b1;
        end else if (b == CH_SEMI) begin
          pcount_next = push_cnt;
          first_next  = push_first;
          second_next = push_second;
          accum_next  = '0;
          have_next   = 1'b0;
        end else begin
          pcount_next  = eff_cnt;
          first_next   = eff_first;
          second_next  = eff_second;
          accum_next   = '0;
          have_next    = 1'b0;
          phase_next   = PH_IDLE;
          result.valid = 1'b1;
          if (intro == CH_CSI) begin
            result.word.key_code = csi_key;
            if (size_upd) begin
              rows_next = eff_first;
              cols_next = eff_second;
            end
          end else if (intro == CH_SS3) begin
            result.word.key_code = ss3_key(b);
          end
        end
      end
      default: begin
        if (!eoi && b == CH_ESC) begin
          phase_next = PH_INTRO;
        end
      end
    endcase
    result.word.screen_rows = rows_next;
    result.word.screen_cols = cols_next;
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      intro  <= '0;
      accum  <= '0;
      have   <= 1'b0;
      pcount <= '0;
      first  <= '0;
      second <= '0;
      rows   <= '0;
      cols   <= '0;
    end else if (fire) begin
      phase  <= phase_next;
      intro  <= intro_next;
      accum  <= accum_next;
      have   <= have_next;
      pcount <= pcount_next;
      first  <= first_next;
      second <= second_next;
      rows   <= rows_next;
      cols   <= cols_next;
    end
  end

endmodule

// ===== src/tksd_out_reg.sv =====
module tksd_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  tksd_pkg::out_word_t load_word,
  output logic                free,
  output logic                out_valid,
  input  logic                out_ready,
  output tksd_pkg::out_word_t out_word
);
  import tksd_pkg::*;

  // Slot can take a new word when empty or being read out
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      out_word <= load_word;
    end
  end

endmodule

// ===== src/terminal_key_sequence_decoder_top.sv =====
// Terminal key sequence decoder.
// A byte that ends a sequence is held in the input register, then decoded into the
// output register, which presents its key word.
// Throughput: one byte per cycle while the key side is ready; the output register
// slot sets the stall point.
// Reset: synchronous rst clears both handshake stages and all parser state to idle.
module terminal_key_sequence_decoder_top #(
  parameter int MaxParams = tksd_pkg::MAX_PARAMS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  tksd_pkg::in_word_t  byte_word,
  output logic                key_valid,
  input  logic                key_ready,
  output tksd_pkg::out_word_t key_word
);
  import tksd_pkg::*;

  logic     held_valid;
  in_word_t held_word;
  logic     slot_free;
  logic     fire;
  result_t  result;

  // Stage advances when the output slot can hold any word it makes
  assign fire = held_valid && slot_free;

  tksd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (byte_valid),
    .in_ready   (byte_ready),
    .in_word    (byte_word),
    .take       (fire),
    .held_valid (held_valid),
    .held_word  (held_word)
  );

  tksd_core #(
    .MaxParams (MaxParams)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .word   (held_word),
    .result (result)
  );

  tksd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire && result.valid),
    .load_word (result.word),
    .free      (slot_free),
    .out_valid (key_valid),
    .out_ready (key_ready),
    .out_word  (key_word)
  );

`ifndef SYNTHESIS
  // A held byte that cannot advance stays held
  a_hold: assert property (@(posedge clk) disable iff (rst)
    held_valid && !fire |=> held_valid)
    else $error("held byte lost");

  // A decoded result shows on the key port next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    fire && result.valid |=> key_valid)
    else $error("result not presented");

  // Key word drained with nothing new loaded leaves the port empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    key_valid && key_ready && !(fire && result.valid) |=> !key_valid)
    else $error("key word repeated");

  // Only key codes up to KEY_SIZE_SAME leave the block
  a_code: assert property (@(posedge clk) disable iff (rst)
    key_valid |-> key_word.key_code <= KEY_SIZE_SAME)
    else $error("bad key code");
`endif

endmodule

// ===== tb/tb_terminal_key_sequence_decoder_top.sv =====
`timescale 1ns / 1ps

module tb_terminal_key_sequence_decoder_top;
  import tksd_pkg::*;

  // Modifier fields of ESC [ 1 ; 5 x
  localparam int CtrlModFirst  = 1;
  localparam int CtrlModSecond = 5;
  localparam int NumMax        = 65535;
  localparam int RandItems     = 1400;

  // One row of the byte plan: the word to send, plus an optional typed key
  typedef struct packed {
    logic            fixed;
    logic [KeyW-1:0] key;
    in_word_t        word;
  } plan_row_t;

  // Directed table; typed keys only where they are obvious
  localparam int DirRows = 26;
  localparam plan_row_t DIRECTED [DirRows] = '{
    '{1'b0, KEY_NONE, '{8'h00,   1'b0}},   // idle: plain byte
    '{1'b0, KEY_NONE, '{8'hFF,   1'b1}},   // idle: end of input
    '{1'b0, KEY_NONE, '{CH_ESC,  1'b0}},
    '{1'b1, KEY_ESC,  '{8'h00,   1'b1}},   // lone Esc
    '{1'b0, KEY_NONE, '{CH_ESC,  1'b0}},
    '{1'b0, KEY_NONE, '{CH_CSI,  1'b0}},
    '{1'b1, KEY_UP,   '{CH_A,    1'b0}},
    '{1'b0, KEY_NONE, '{CH_ESC,  1'b0}},
    '{1'b0, KEY_NONE, '{CH_SS3,  1'b0}},
    '{1'b1, KEY_F1,   '{CH_P,    1'b0}},
    '{1'b0, KEY_NONE, '{CH_ESC,  1'b0}},
    '{1'b0, KEY_NONE, '{CH_CSI,  1'b0}},
    '{1'b1, KEY_NONE, '{8'hFF,   1'b1}},   // end of input inside CSI
    '{1'b0, KEY_NONE, '{CH_ESC,  1'b0}},
    '{1'b0, KEY_NONE, '{8'hFF,   1'b0}},   // odd introducer
    '{1'b1, KEY_ALT,  '{8'h00,   1'b1}},
    '{1'b0, KEY_NONE, '{CH_ESC,  1'b0}},
    '{1'b0, KEY_NONE, '{CH_CSI,  1'b0}},
    '{1'b0, KEY_NONE, '{CH_9,    1'b0}},   // 99999 saturates
    '{1'b0, KEY_NONE, '{CH_9,    1'b0}},
    '{1'b0, KEY_NONE, '{CH_9,    1'b0}},
    '{1'b0, KEY_NONE, '{CH_9,    1'b0}},
    '{1'b0, KEY_NONE, '{CH_9,    1'b0}},
    '{1'b0, KEY_NONE, '{CH_SEMI, 1'b0}},
    '{1'b0, KEY_NONE, '{CH_0,    1'b0}},
    '{1'b0, KEY_NONE, '{CH_R,    1'b0}}    // size report, max rows
  };

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_ready;
  in_word_t  byte_word = '0;
  logic      key_valid;
  logic      key_ready = 1'b0;
  out_word_t key_word;

  terminal_key_sequence_decoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .byte_word (byte_word),
    .key_valid (key_valid),
    .key_ready (key_ready),
    .key_word  (key_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  plan_row_t byte_plan[$];
  out_word_t pending_keys[$];
  int        sent_cnt  = 0;
  int        taken_cnt = 0;
  int        keys_seen = 0;
  int        errors    = 0;
  int        key_hits[32];
  int        tx_gap = 0;
  int        rx_gap = 0;
  logic      calm = 1'b0;
  logic      hold_off = 1'b0;

  // Decoder shadow state
  phase_t          sh_phase  = PH_IDLE;
  logic [ByteW-1:0] sh_intro = '0;
  int              sh_accum  = 0;
  bit              sh_digits = 1'b0;
  int              sh_count  = 0;
  logic [NumW-1:0] sh_first  = '0;
  logic [NumW-1:0] sh_second = '0;
  logic [NumW-1:0] held_rows = '0;
  logic [NumW-1:0] held_cols = '0;

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Close the current field; extra fields past the limit are dropped
  task automatic close_field();
    if (sh_count < MAX_PARAMS) begin
      if (sh_count == 0) sh_first = sh_accum[NumW-1:0];
      else if (sh_count == 1) sh_second = sh_accum[NumW-1:0];
      sh_count++;
    end
    sh_accum  = 0;
    sh_digits = 1'b0;
  endtask

  function automatic logic [KeyW-1:0] tilde_code(input logic [NumW-1:0] n);
    case (n)
      16'd2:   return KEY_INSERT;
      16'd3:   return KEY_DELETE;
      16'd5:   return KEY_PGUP;
      16'd6:   return KEY_PGDN;
      16'd15:  return KEY_F5;
      16'd17:  return KEY_F6;
      16'd18:  return KEY_F7;
      16'd19:  return KEY_F8;
      16'd20:  return KEY_F9;
      16'd21:  return KEY_F10;
      16'd23:  return KEY_F11;
      16'd24:  return KEY_F12;
      default: return KEY_NONE;
    endcase
  endfunction

  function automatic logic [KeyW-1:0] ss3_code(input logic [ByteW-1:0] fin);
    if (fin >= CH_A && fin <= CH_D) return KEY_UP + KeyW'(fin - CH_A);
    if (fin >= CH_P && fin <= CH_S) return KEY_F1 + KeyW'(fin - CH_P);
    return KEY_NONE;
  endfunction

  // CSI final byte; a size report also updates the held screen size
  task automatic csi_final(input logic [ByteW-1:0] fin, output logic [KeyW-1:0] kc);
    kc = KEY_NONE;
    if (fin >= CH_A && fin <= CH_D) begin
      if (sh_count == 2 && sh_first == CtrlModFirst && sh_second == CtrlModSecond)
        kc = KEY_CTRL_UP + KeyW'(fin - CH_A);
      else if (sh_count == 0)
        kc = KEY_UP + KeyW'(fin - CH_A);
    end else if (fin == CH_TILDE) begin
      if (sh_count == 1) kc = tilde_code(sh_first);
    end else if (fin == CH_R && sh_count == 2) begin
      kc = (held_rows != sh_first || held_cols != sh_second) ? KEY_SIZE_NEW : KEY_SIZE_SAME;
      held_rows = sh_first;
      held_cols = sh_second;
    end
  endtask

  // Advance the shadow decoder by one accepted word
  task automatic decode_byte(input in_word_t iw, output bit got, output out_word_t ow);
    logic [KeyW-1:0] kc;
    logic [ByteW-1:0] b;
    b   = iw.rx_byte;
    got = 1'b0;
    kc  = KEY_NONE;
    ow  = '0;
    case (sh_phase)
      PH_INTRO: begin
        if (iw.end_of_input) begin
          sh_phase = PH_IDLE;
          kc  = KEY_ESC;
          got = 1'b1;
        end else begin
          sh_intro  = b;
          sh_accum  = 0;
          sh_digits = 1'b0;
          sh_count  = 0;
          sh_first  = '0;
          sh_second = '0;
          sh_phase  = PH_PARAM;
        end
      end
      PH_PARAM: begin
        if (iw.end_of_input) begin
          if (sh_digits) close_field();
          kc  = (sh_intro == CH_CSI || sh_intro == CH_SS3) ? KEY_NONE : KEY_ALT;
          got = 1'b1;
          sh_phase = PH_IDLE;
        end else if (b >= CH_0 && b <= CH_9) begin
          sh_accum  = sh_accum * 10 + int'(b - CH_0);
          if (sh_accum > NumMax) sh_accum = NumMax;
          sh_digits = 1'b1;
        end else if (b == CH_SEMI) begin
          close_field();
        end else begin
          if (sh_digits) close_field();
          if (sh_intro == CH_CSI) csi_final(b, kc);
          else if (sh_intro == CH_SS3) kc = ss3_code(b);
          got = 1'b1;
          sh_phase = PH_IDLE;
        end
      end
      default: begin
        sh_phase = (!iw.end_of_input && b == CH_ESC) ? PH_INTRO : PH_IDLE;
      end
    endcase
    if (got) begin
      ow.key_code    = kc;
      ow.screen_rows = held_rows;
      ow.screen_cols = held_cols;
    end
  endtask

  // Plan builders
  task automatic put(input logic [ByteW-1:0] b);
    plan_row_t r;
    r = '0;
    r.word.rx_byte = b;
    byte_plan.push_back(r);
  endtask

  task automatic put_eoi();
    plan_row_t r;
    r = '0;
    r.word.rx_byte      = ByteW'($urandom);
    r.word.end_of_input = 1'b1;
    byte_plan.push_back(r);
  endtask

  function automatic int rand_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 30);
    if (r < 85) return $urandom_range(0, NumMax);
    return $urandom_range(NumMax + 1, 9999999);
  endfunction

  task automatic put_number(input int v);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 9) == 0) put(CH_0);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  // n fields separated by ';', some of them empty
  task automatic put_fields(input int n);
    for (int i = 0; i < n; i++) begin
      if (i > 0) put(CH_SEMI);
      if ($urandom_range(0, 4) != 0) put_number(rand_value());
    end
  endtask

  function automatic int pick_dim();
    int sizes[4] = '{24, 25, 80, 132};
    if ($urandom_range(0, 9) < 7) return sizes[$urandom_range(0, 3)];
    return rand_value();
  endfunction

  function automatic logic [ByteW-1:0] pick_final();
    case ($urandom_range(0, 5))
      0, 1:    return CH_A + ByteW'($urandom_range(0, 3));
      2:       return CH_TILDE;
      3:       return CH_R;
      default: return ByteW'($urandom);
    endcase
  endfunction

  // One random sequence, mostly well formed
  task automatic add_sequence();
    int r;
    r = $urandom_range(0, 99);
    if (r < 82) put(CH_ESC);
    if (r < 14) begin
      put(CH_CSI);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: ;
        5, 6, 7: begin
          put_number(CtrlModFirst);
          put(CH_SEMI);
          put_number(CtrlModSecond);
        end
        default: put_fields($urandom_range(1, 3));
      endcase
      put(CH_A + ByteW'($urandom_range(0, 3)));
    end else if (r < 28) begin
      int codes[12] = '{2, 3, 5, 6, 15, 17, 18, 19, 20, 21, 23, 24};
      put(CH_CSI);
      if ($urandom_range(0, 4) != 0) put_number(codes[$urandom_range(0, 11)]);
      else put_fields($urandom_range(0, 2));
      put(CH_TILDE);
    end else if (r < 40) begin
      put(CH_SS3);
      case ($urandom_range(0, 4))
        0, 1:    put(CH_A + ByteW'($urandom_range(0, 3)));
        2, 3:    put(CH_P + ByteW'($urandom_range(0, 3)));
        default: begin
          put_fields($urandom_range(0, 2));
          put(ByteW'($urandom));
        end
      endcase
    end else if (r < 55) begin
      put(CH_CSI);
      put_number(pick_dim());
      put(CH_SEMI);
      put_number(pick_dim());
      put(CH_R);
    end else if (r < 67) begin
      put(CH_CSI);
      put_fields($urandom_range(0, 13));
      put(pick_final());
    end else if (r < 75) begin
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 2))
          0:       put(CH_CSI);
          1:       put(CH_SS3);
          default: put(ByteW'($urandom));
        endcase
        put_fields($urandom_range(0, 3));
      end
      put_eoi();
    end else if (r < 82) begin
      put(ByteW'($urandom));
      put_fields($urandom_range(0, 3));
      put(pick_final());
    end else begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 4) == 0) put_eoi();
        else put(ByteW'($urandom));
      end
    end
  endtask

  // Mostly short gaps, a few long ones; none during a calm stretch
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Alternate calm stretches with idling ones
  initial begin
    forever begin
      repeat ($urandom_range(100, 500)) @(posedge clk);
      calm <= 1'b1;
      repeat ($urandom_range(30, 150)) @(posedge clk);
      calm <= 1'b0;
    end
  end

  // Long receiver hold-off once the stream is going
  initial begin
    while (taken_cnt < 200) @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Byte side
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!byte_valid || byte_ready) begin
      if (tx_gap > 0 && !hold_off) begin
        byte_valid <= 1'b0;
        tx_gap     <= tx_gap - 1;
      end else if (sent_cnt < byte_plan.size()) begin
        byte_valid <= 1'b1;
        byte_word  <= byte_plan[sent_cnt].word;
        sent_cnt   <= sent_cnt + 1;
        tx_gap     <= pick_gap();
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  // Key side
  always @(posedge clk) begin
    if (rst) begin
      key_ready <= 1'b0;
    end else if (hold_off) begin
      key_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      key_ready <= 1'b0;
      rx_gap    <= rx_gap - 1;
    end else begin
      key_ready <= 1'b1;
      if (key_valid && key_ready) rx_gap <= pick_gap();
    end
  end

  // Check key words, then predict from the accepted byte word
  always @(posedge clk) begin : monitor
    out_word_t want;
    out_word_t pred;
    bit        got;
    if (!rst) begin
      if (key_valid && key_ready) begin
        keys_seen++;
        key_hits[key_word.key_code]++;
        if (pending_keys.size() == 0) begin
          report_mismatch($sformatf("unexpected key word %0d", key_word.key_code));
        end else begin
          want = pending_keys.pop_front();
          if (key_word.key_code !== want.key_code)
            report_mismatch($sformatf("key_code %0d, want %0d",
                                      key_word.key_code, want.key_code));
          if (key_word.screen_rows !== want.screen_rows)
            report_mismatch($sformatf("screen_rows %0d, want %0d",
                                      key_word.screen_rows, want.screen_rows));
          if (key_word.screen_cols !== want.screen_cols)
            report_mismatch($sformatf("screen_cols %0d, want %0d",
                                      key_word.screen_cols, want.screen_cols));
        end
      end
      if (byte_valid && byte_ready) begin
        decode_byte(byte_word, got, pred);
        if (byte_plan[taken_cnt].fixed) begin
          got = 1'b1;
          pred.key_code    = byte_plan[taken_cnt].key;
          pred.screen_rows = held_rows;
          pred.screen_cols = held_cols;
        end
        if (got) pending_keys.push_back(pred);
        taken_cnt++;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d of %0d bytes taken, %0d keys pending",
             taken_cnt, byte_plan.size(), pending_keys.size());
    $display("tb_terminal_key_sequence_decoder_top: FAIL");
    $finish;
  end

  initial begin : main
    int codes_hit;
    foreach (key_hits[i]) key_hits[i] = 0;
    foreach (DIRECTED[i]) byte_plan.push_back(DIRECTED[i]);
    while (byte_plan.size() < DirRows + RandItems) add_sequence();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (taken_cnt < byte_plan.size()) @(posedge clk);
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    codes_hit = 0;
    foreach (key_hits[i]) if (key_hits[i] != 0) codes_hit++;
    $display("run: %0d bytes decoded, %0d key words checked, %0d distinct key codes",
             taken_cnt, keys_seen, codes_hit);
    $display("run: %0d size reports changed, %0d unchanged, %0d mismatches",
             key_hits[KEY_SIZE_NEW], key_hits[KEY_SIZE_SAME], errors);
    if (errors == 0) begin
      $display("tb_terminal_key_sequence_decoder_top: PASS");
    end else begin
      $display("tb_terminal_key_sequence_decoder_top: FAIL");
    end
    $finish;
  end

endmodule
